// File: design/bspp_pkg.sv
package bspp_pkg;

	localparam int MAX_FRAME_BYTES = 255;
	localparam int OFFSET_W = $clog2(MAX_FRAME_BYTES + 1);

	// Frame-control flags.
	localparam logic [15:0] FC_ENCRYPTED  = 16'h0008;
	localparam logic [15:0] FC_HAS_ADDR   = 16'h0010;
	localparam logic [15:0] FC_HAS_CAPAB  = 16'h0020;
	localparam logic [15:0] FC_HAS_OBJECT = 16'h0040;

	// Object type codes.
	localparam logic [15:0] OBJ_TEMP     = 16'h1004;
	localparam logic [15:0] OBJ_HUM      = 16'h1006;
	localparam logic [15:0] OBJ_TEMP_HUM = 16'h100D;
	localparam logic [15:0] OBJ_BATT     = 16'h100A;

	localparam logic [15:0] PRODUCT_RESET = 16'h01AA;

	// Frame status codes.
	localparam logic [2:0] ST_ACCEPTED   = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
	localparam logic [2:0] ST_ENCRYPTED  = 3'd2;
	localparam logic [2:0] ST_NO_ADDRESS = 3'd3;
	localparam logic [2:0] ST_FILTERED   = 3'd4;
	localparam logic [2:0] ST_NO_OBJECTS = 3'd5;
	localparam logic [2:0] ST_NO_DATA    = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FILTER  = 2'd0;
	localparam logic [1:0] CFG_ADDRESS = 2'd1;
	localparam logic [1:0] CFG_PRODUCT = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_CAPAB,
		PH_OBJHDR,
		PH_OBJVAL
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         frame_status;
		logic signed [15:0] temperature_tenths;
		logic [15:0]        humidity_tenths;
		logic [7:0]         battery_percent;
		logic [47:0]        sensor_address;
		logic [15:0]        frame_product;
	} result_t;

	typedef struct packed {
		logic        filter_by_address;
		logic [47:0] wanted_address;
		logic [15:0] wanted_product;
	} cfg_t;

endpackage

// File: design/bspp_in_queue.sv
module bspp_in_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bspp_pkg::in_item_t item,
	output logic              avail,
	input  logic              take,
	output bspp_pkg::in_item_t head
);
	import bspp_pkg::*;

	in_item_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	assign full  = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head  = mem_q[rd_q];
	assign wr_en = push && !full;
	assign rd_en = take && avail;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/bspp_out_queue.sv
module bspp_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  bspp_pkg::result_t data,
	output logic             empty,
	input  logic             pop,
	output bspp_pkg::result_t head
);
	import bspp_pkg::*;

	result_t    mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_q];
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/bspp_parser.sv
module bspp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  bspp_pkg::cfg_t     cfg,
	input  logic               in_avail,
	input  bspp_pkg::in_item_t in_head,
	output logic               in_take,
	input  logic               res_full,
	output logic               res_push,
	output bspp_pkg::result_t  res_data
);
	import bspp_pkg::*;

	phase_t              phase_q, phase_d;
	logic [OFFSET_W-1:0] offset_q, offset_d;
	logic [15:0]         fc_q, fc_d;
	logic [15:0]         pc_q, pc_d;
	logic [47:0]         addr_q, addr_d;
	logic [15:0]         type_q, type_d;
	logic [7:0]          len_q, len_d;
	logic [7:0]          seen_q, seen_d;
	logic [31:0]         value_q, value_d;
	logic [15:0]         pend_t_q, pend_t_d;
	logic [15:0]         pend_h_q, pend_h_d;
	logic [7:0]          pend_b_q, pend_b_d;
	logic                pvalid_q, pvalid_d;
	logic [15:0]         st_t_q, st_t_d;
	logic [15:0]         st_h_q, st_h_d;
	logic [7:0]          st_b_q, st_b_d;
	logic [47:0]         st_a_q, st_a_d;
	logic [2:0]          status;
	logic [OFFSET_W-1:0] count;

	assign in_take  = in_avail && !res_full;
	assign res_push = in_take && in_head.last_byte;

	always_comb begin
		logic       start;
		logic       apply;
		logic       mismatch;
		logic [7:0] b;
		logic [7:0] seen_inc;

		b     = in_head.payload_byte;
		start = (offset_q == '0) && (phase_q == PH_HEADER);
		apply = 1'b0;

		// A new frame clears the header and object state and reloads readings.
		fc_d     = start ? '0 : fc_q;
		pc_d     = start ? '0 : pc_q;
		addr_d   = start ? '0 : addr_q;
		type_d   = start ? '0 : type_q;
		len_d    = start ? '0 : len_q;
		seen_d   = start ? '0 : seen_q;
		value_d  = start ? '0 : value_q;
		pend_t_d = start ? st_t_q : pend_t_q;
		pend_h_d = start ? st_h_q : pend_h_q;
		pend_b_d = start ? st_b_q : pend_b_q;
		pvalid_d = start ? 1'b0 : pvalid_q;
		phase_d  = phase_q;
		st_t_d   = st_t_q;
		st_h_d   = st_h_q;
		st_b_d   = st_b_q;
		st_a_d   = st_a_q;
		seen_inc = seen_q + 8'd1;

		case (phase_q)
			PH_HEADER: begin
				if (offset_q == OFFSET_W'(0)) fc_d[7:0] = b;
				if (offset_q == OFFSET_W'(1)) fc_d[15:8] = b;
				if (offset_q == OFFSET_W'(2)) pc_d[7:0] = b;
				if (offset_q == OFFSET_W'(3)) pc_d[15:8] = b;
				for (int i = 0; i < 6; i++) begin
					if (offset_q == OFFSET_W'(5 + i)) addr_d[8*i +: 8] = b;
				end
				if (offset_q >= OFFSET_W'(10)) begin
					phase_d = ((fc_d & FC_HAS_CAPAB) != '0) ? PH_CAPAB : PH_OBJHDR;
					seen_d  = '0;
				end
			end
			PH_CAPAB: begin
				phase_d = PH_OBJHDR;
				seen_d  = '0;
			end
			PH_OBJHDR: begin
				if (seen_q == 8'd0) begin
					type_d = {8'h00, b};
					seen_d = 8'd1;
				end else if (seen_q == 8'd1) begin
					type_d[15:8] = b;
					seen_d       = 8'd2;
				end else begin
					len_d   = b;
					value_d = '0;
					seen_d  = '0;
					if (b == 8'd0) begin
						apply = 1'b1;
					end else begin
						phase_d = PH_OBJVAL;
					end
				end
			end
			PH_OBJVAL: begin
				if (seen_q < 8'd4) value_d[{seen_q[1:0], 3'b000} +: 8] = b;
				seen_d = seen_inc;
				if (seen_inc >= len_d) begin
					apply   = 1'b1;
					phase_d = PH_OBJHDR;
					seen_d  = '0;
				end
			end
			default: phase_d = PH_HEADER;
		endcase

		// A complete known object of sufficient length updates the readings.
		if (apply) begin
			if (type_d == OBJ_TEMP && len_d >= 8'd2) begin
				pend_t_d = value_d[15:0];
				pvalid_d = 1'b1;
			end else if (type_d == OBJ_HUM && len_d >= 8'd2) begin
				pend_h_d = value_d[15:0];
				pvalid_d = 1'b1;
			end else if (type_d == OBJ_TEMP_HUM && len_d >= 8'd4) begin
				pend_t_d = value_d[15:0];
				pend_h_d = value_d[31:16];
				pvalid_d = 1'b1;
			end else if (type_d == OBJ_BATT && len_d >= 8'd1) begin
				pend_b_d = value_d[7:0];
				pvalid_d = 1'b1;
			end
		end

		count = (offset_q < OFFSET_W'(MAX_FRAME_BYTES)) ? offset_q + OFFSET_W'(1)
		                                                 : OFFSET_W'(MAX_FRAME_BYTES);
		offset_d = count;

		mismatch = cfg.filter_by_address ? (addr_d != cfg.wanted_address)
		                                 : (pc_d != cfg.wanted_product);
		if (count < OFFSET_W'(5))
			status = ST_TOO_SHORT;
		else if ((fc_d & FC_ENCRYPTED) != '0)
			status = ST_ENCRYPTED;
		else if ((fc_d & FC_HAS_ADDR) == '0 || count < OFFSET_W'(11))
			status = ST_NO_ADDRESS;
		else if (mismatch)
			status = ST_FILTERED;
		else if ((fc_d & FC_HAS_OBJECT) == '0)
			status = ST_NO_OBJECTS;
		else if (!pvalid_d)
			status = ST_NO_DATA;
		else
			status = ST_ACCEPTED;

		if (in_head.last_byte) begin
			if (status == ST_ACCEPTED) begin
				st_t_d = pend_t_d;
				st_h_d = pend_h_d;
				st_b_d = pend_b_d;
				st_a_d = addr_d;
			end
			phase_d  = PH_HEADER;
			offset_d = '0;
			seen_d   = '0;
		end

		res_data.frame_status       = status;
		res_data.temperature_tenths = st_t_d;
		res_data.humidity_tenths    = st_h_d;
		res_data.battery_percent    = st_b_d;
		res_data.sensor_address     = st_a_d;
		res_data.frame_product      = (count >= OFFSET_W'(4)) ? pc_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			offset_q <= '0;
			fc_q     <= '0;
			pc_q     <= '0;
			addr_q   <= '0;
			type_q   <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			value_q  <= '0;
			pend_t_q <= '0;
			pend_h_q <= '0;
			pend_b_q <= '0;
			pvalid_q <= 1'b0;
			st_t_q   <= '0;
			st_h_q   <= '0;
			st_b_q   <= '0;
			st_a_q   <= '0;
		end else if (in_take) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			fc_q     <= fc_d;
			pc_q     <= pc_d;
			addr_q   <= addr_d;
			type_q   <= type_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			value_q  <= value_d;
			pend_t_q <= pend_t_d;
			pend_h_q <= pend_h_d;
			pend_b_q <= pend_b_d;
			pvalid_q <= pvalid_d;
			st_t_q   <= st_t_d;
			st_h_q   <= st_h_d;
			st_b_q   <= st_b_d;
			st_a_q   <= st_a_d;
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && in_head.last_byte |=> phase_q == PH_HEADER && offset_q == '0)
		else $error("frame end did not restart the parser");

	a_offset_counts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !in_head.last_byte && offset_q != OFFSET_W'(MAX_FRAME_BYTES)
		|=> offset_q == $past(offset_q) + OFFSET_W'(1))
		else $error("byte offset did not advance");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_value_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OBJVAL |-> len_q != 8'd0)
		else $error("value phase with zero object length");

	a_commit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_take && in_head.last_byte && status == ST_ACCEPTED) |=> $stable(st_a_q))
		else $error("stored address changed without an accepted frame");

endmodule

// File: design/beacon_sensor_payload_parser_unit.sv
// Channel   Direction  Handshake               Payload
// input     in         push / full             item (payload_byte, last_byte)
// result    out        empty / pop             result (status, readings, address)
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is parsed per cycle while the parser is not stalled; a frame's result
// is in the result queue on the cycle after its last byte is parsed.
// Input and results each pass a two-entry queue, so the parser keeps taking bytes
// while one result waits; it stalls only while the result queue is full.
// Reset clears the parser, both queues and the registers (wanted product 0x01AA).
// Configuration is always ready; the user must write it only while no frame is in flight (not enforced).
module beacon_sensor_payload_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  bspp_pkg::in_item_t item,
	output logic               empty,
	input  logic               pop,
	output bspp_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);
	import bspp_pkg::*;

	cfg_t     cfg_q;
	logic     in_avail;
	logic     in_take;
	in_item_t in_head;
	logic     res_full;
	logic     res_push;
	result_t  res_data;

	// Register writes are registered; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_by_address <= 1'b0;
			cfg_q.wanted_address    <= '0;
			cfg_q.wanted_product    <= PRODUCT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FILTER:  cfg_q.filter_by_address <= cfg_data[0];
				CFG_ADDRESS: cfg_q.wanted_address    <= cfg_data;
				CFG_PRODUCT: cfg_q.wanted_product    <= cfg_data[15:0];
				default:     cfg_q                   <= cfg_q;
			endcase
		end
	end

	// The front queue decouples the byte source from the parser.
	bspp_in_queue u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.avail  (in_avail),
		.take   (in_take),
		.head   (in_head)
	);

	// The parser walks the frame and judges it at the final byte.
	bspp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_avail (in_avail),
		.in_head  (in_head),
		.in_take  (in_take),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	// Finished results wait here until the consumer pops them.
	bspp_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.data   (res_data),
		.empty  (empty),
		.pop    (pop),
		.head   (result)
	);

endmodule
